// ----- sv/mdss_pkg.sv -----
package mdss_pkg;

   // Largest graph the block is built for by default.
   localparam int DEF_MAX_NODES = 64;

   // Node counts, degrees, depths and cover counts all fit 0..64.
   localparam int CNT_W  = 7;
   // Degree sum of the whole graph, up to 64 * 64.
   localparam int REM_W  = 13;
   // Endpoint field width on the request channel.
   localparam int NODE_W = 6;

   localparam logic MODE_EDGE  = 1'b0;
   localparam logic MODE_SOLVE = 1'b1;

   localparam logic             CSR_IDX_NODE_COUNT = 1'b0;
   localparam logic [CNT_W-1:0] NODE_COUNT_RESET   = 7'd64;

   // Branch phase of one search frame.
   localparam logic [1:0] PH_INCLUDE = 2'd0;
   localparam logic [1:0] PH_EXCLUDE = 2'd1;
   localparam logic [1:0] PH_POP     = 2'd2;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CNT_W-1:0] count;
   } pc_status_type;

endpackage

// ----- sv/mdss_ram.sv -----
module mdss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/mdss_popcnt.sv -----
module mdss_popcnt #(
   parameter int WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [WIDTH-1:0]           vec,
   output mdss_pkg::pc_status_type    status
);
   import mdss_pkg::*;

   localparam int STEPS = (WIDTH + 7) / 8;
   localparam int SH_W  = STEPS * 8;
   localparam int SW    = $clog2(STEPS + 1);

   logic [SH_W-1:0]  sh_ff, sh_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic             done_ff, done_in;
   logic [3:0]       chunk_cnt;

   // Count one byte of the word per cycle.
   always_comb begin
      chunk_cnt = 4'd0;
      for (int k = 0; k < 8; k++) begin
         chunk_cnt = chunk_cnt + 4'(sh_ff[k]);
      end
   end

   always_comb begin
      sh_in   = sh_ff;
      step_in = step_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in   = SH_W'(vec);
         step_in = SW'(STEPS);
         acc_in  = '0;
      end else if (step_ff != '0) begin
         sh_in   = sh_ff >> 8;
         step_in = step_ff - SW'(1);
         acc_in  = acc_ff + CNT_W'(chunk_cnt);
         done_in = (step_ff == SW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
   end

   assign status.busy  = (step_ff != '0);
   assign status.done  = done_ff;
   assign status.count = acc_ff;

endmodule

// ----- sv/minimum_dominating_set_search.sv -----
// Channel   | Dir | Contents (lowest bits first)
// req       | in  | tdata: node_a[5:0], node_b[11:6]; tuser: mode
// rsp       | out | tdata: min_count[6:0], chosen_set[70:7]
// csr       | in  | APB, node_count at byte address 0
//
// An edge request does a read-modify-write of two adjacency rows in one RAM port.
// A solve request finds the degrees, ranks the nodes and forms the greedy bound, then per
// search frame does a prune check and reads, an include step (the shared byte-serial
// popcount gives the cover count), an exclude step and a return to a parent frame.
// Synchronous active-high reset empties the graph at once (row valid bits) and sets
// node_count to 64. req_tready is high only while idle; a finished result waits in the
// rsp register while edges for the next graph are taken.
module minimum_dominating_set_search #(
   parameter int MAX_NODES = mdss_pkg::DEF_MAX_NODES
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // node_a[5:0], node_b[11:6], zero fill
   input  logic [0:0]  req_tuser,   // mode
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // min_count[6:0], chosen_set[70:7], zero fill
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mdss_pkg::*;

   localparam int N_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic [CNT_W-1:0]     MAX_N   = CNT_W'(MAX_NODES);
   localparam logic [MAX_NODES-1:0] ONE_BIT = MAX_NODES'(1);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_E_WRA  = 5'd1;
   localparam logic [4:0] ST_E_RDB  = 5'd2;
   localparam logic [4:0] ST_E_WRB  = 5'd3;
   localparam logic [4:0] ST_DG_RD  = 5'd4;
   localparam logic [4:0] ST_DG_PC  = 5'd5;
   localparam logic [4:0] ST_DG_WT  = 5'd6;
   localparam logic [4:0] ST_RK_RD  = 5'd7;
   localparam logic [4:0] ST_RK_CMP = 5'd8;
   localparam logic [4:0] ST_GR_RD  = 5'd9;
   localparam logic [4:0] ST_GR_ADJ = 5'd10;
   localparam logic [4:0] ST_GR_UPD = 5'd11;
   localparam logic [4:0] ST_S_INIT = 5'd12;
   localparam logic [4:0] ST_S_FRM  = 5'd13;
   localparam logic [4:0] ST_S_F0   = 5'd14;
   localparam logic [4:0] ST_S_F1   = 5'd15;
   localparam logic [4:0] ST_S_F2   = 5'd16;
   localparam logic [4:0] ST_S_EXEC = 5'd17;
   localparam logic [4:0] ST_S_COV  = 5'd18;
   localparam logic [4:0] ST_S_LEAVE= 5'd19;
   localparam logic [4:0] ST_DONE   = 5'd20;

   logic [4:0]           state_ff, state_in;
   logic [CNT_W-1:0]     node_count_ff, node_count_in;
   logic [NODE_W-1:0]    a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0]     i_ff, i_in, pos_ff, pos_in, dv_ff, dv_in, d_ff, d_in;
   logic [CNT_W-1:0]     used_ff, used_in, best_cnt_ff, best_cnt_in;
   logic [CNT_W-1:0]     covered_ff, covered_in, greedy_ff, greedy_in, saved_ff, saved_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [N_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]     deg_ff, deg_in;
   logic [MAX_NODES-1:0] row_ff, row_in;
   logic [1:0]           phase_ff, phase_in;
   logic                 popping_ff, popping_in, fresh_ff, fresh_in;
   logic [MAX_NODES-1:0] cmask_ff, cmask_in, pick_ff, pick_in;
   logic [MAX_NODES-1:0] chosen_ff, chosen_in, best_set_ff, best_set_in;
   logic [CNT_W-1:0]     visit_ff [MAX_NODES];
   logic [CNT_W-1:0]     visit_in [MAX_NODES];
   logic [MAX_NODES-1:0] row_vld_ff, row_vld_in;
   logic                 row_vld_q_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [71:0]          rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]     n_act;
   logic [MAX_NODES-1:0] mask, cov_vec, adj_row, edge_bits, idx_bit;
   logic                 cfg_wr, in_search;

   // RAM ports
   logic                 adj_we, deg_we, ord_we, frm_we;
   logic [N_W-1:0]       adj_waddr, adj_raddr, deg_waddr, deg_raddr;
   logic [N_W-1:0]       ord_waddr, ord_raddr, frm_waddr, frm_raddr;
   logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
   logic [CNT_W-1:0]     deg_wdata, deg_rdata;
   logic [N_W-1:0]       ord_wdata, ord_rdata;
   logic [CNT_W+1:0]     frm_wdata, frm_rdata;

   logic                 pc_start;
   logic [MAX_NODES-1:0] pc_vec;
   pc_status_type        pc_stat;

   mdss_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_waddr), .wr_data(adj_wdata),
      .rd_addr(adj_raddr), .rd_data(adj_rdata));
   mdss_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_deg_ram (
      .clock(clock), .wr_en(deg_we), .wr_addr(deg_waddr), .wr_data(deg_wdata),
      .rd_addr(deg_raddr), .rd_data(deg_rdata));
   mdss_ram #(.WIDTH(N_W), .DEPTH(MAX_NODES)) u_ord_ram (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_waddr), .wr_data(ord_wdata),
      .rd_addr(ord_raddr), .rd_data(ord_rdata));
   mdss_ram #(.WIDTH(CNT_W + 2), .DEPTH(MAX_NODES)) u_frm_ram (
      .clock(clock), .wr_en(frm_we), .wr_addr(frm_waddr), .wr_data(frm_wdata),
      .rd_addr(frm_raddr), .rd_data(frm_rdata));

   mdss_popcnt #(.WIDTH(MAX_NODES)) u_popcnt (
      .clock(clock), .reset(reset), .start(pc_start), .vec(pc_vec), .status(pc_stat));

   // Register port: one register, always ready.
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;
   assign prdata = (paddr[2] == CSR_IDX_NODE_COUNT) ? 32'(node_count_ff) : 32'd0;

   always_comb begin
      node_count_in = node_count_ff;
      if (cfg_wr && paddr[2] == CSR_IDX_NODE_COUNT) begin
         node_count_in = pwdata[CNT_W-1:0];
      end
   end

   // Clamp node_count into 1..MAX_NODES.
   always_comb begin
      if (node_count_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (node_count_ff > MAX_N) begin
         n_act = MAX_N;
      end else begin
         n_act = node_count_ff;
      end
      for (int j = 0; j < MAX_NODES; j++) begin
         mask[j]    = CNT_W'(j) < n_act;
         cov_vec[j] = visit_ff[j] != '0;
      end
   end

   // A row never written since the last clear reads as empty.
   assign adj_row   = adj_rdata & {MAX_NODES{row_vld_q_ff}} & mask;
   assign edge_bits = (ONE_BIT << a_ff) | (ONE_BIT << b_ff);
   assign idx_bit   = ONE_BIT << idx_ff;

   always_comb begin
      in_search = state_ff inside {[ST_S_FRM:ST_S_LEAVE]};
   end

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      i_in        = i_ff;
      pos_in      = pos_ff;
      dv_in       = dv_ff;
      d_in        = d_ff;
      used_in     = used_ff;
      best_cnt_in = best_cnt_ff;
      covered_in  = covered_ff;
      greedy_in   = greedy_ff;
      saved_in    = saved_ff;
      rem_in      = rem_ff;
      idx_in      = idx_ff;
      deg_in      = deg_ff;
      row_in      = row_ff;
      phase_in    = phase_ff;
      popping_in  = popping_ff;
      fresh_in    = fresh_ff;
      cmask_in    = cmask_ff;
      pick_in     = pick_ff;
      chosen_in   = chosen_ff;
      best_set_in = best_set_ff;
      visit_in    = visit_ff;
      row_vld_in  = row_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      adj_we    = 1'b0;
      adj_waddr = a_ff[N_W-1:0];
      adj_wdata = (adj_rdata & {MAX_NODES{row_vld_q_ff}}) | edge_bits;
      adj_raddr = i_ff[N_W-1:0];
      deg_we    = 1'b0;
      deg_waddr = i_ff[N_W-1:0];
      deg_wdata = pc_stat.count;
      deg_raddr = i_ff[N_W-1:0];
      ord_we    = 1'b0;
      ord_waddr = pos_ff[N_W-1:0];
      ord_wdata = i_ff[N_W-1:0];
      ord_raddr = i_ff[N_W-1:0];
      frm_we    = 1'b0;
      frm_waddr = d_ff[N_W-1:0];
      frm_wdata = {PH_EXCLUDE, saved_ff};
      frm_raddr = d_ff[N_W-1:0];
      pc_start  = 1'b0;
      pc_vec    = adj_row;

      case (state_ff)
         ST_IDLE: begin
            // Start the read of row a as the request is taken.
            adj_raddr = req_tdata[N_W-1:0];
            if (req_tvalid) begin
               a_in = req_tdata[NODE_W-1:0];
               b_in = req_tdata[2*NODE_W-1:NODE_W];
               if (req_tuser[0] == MODE_SOLVE) begin
                  i_in     = '0;
                  rem_in   = '0;
                  state_in = ST_DG_RD;
               end else begin
                  state_in = ST_E_WRA;
               end
            end
         end
         ST_E_WRA: begin
            adj_we    = ({1'b0, a_ff} < MAX_N);
            adj_waddr = a_ff[N_W-1:0];
            if (adj_we) begin
               row_vld_in[a_ff[N_W-1:0]] = 1'b1;
            end
            state_in = ST_E_RDB;
         end
         ST_E_RDB: begin
            adj_raddr = b_ff[N_W-1:0];
            state_in  = ST_E_WRB;
         end
         ST_E_WRB: begin
            adj_we    = ({1'b0, b_ff} < MAX_N);
            adj_waddr = b_ff[N_W-1:0];
            if (adj_we) begin
               row_vld_in[b_ff[N_W-1:0]] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         // Degree of each node: popcount of its masked row.
         ST_DG_RD: begin
            state_in = ST_DG_PC;
         end
         ST_DG_PC: begin
            pc_start = 1'b1;
            state_in = ST_DG_WT;
         end
         ST_DG_WT: begin
            if (pc_stat.done) begin
               deg_we = 1'b1;
               rem_in = rem_ff + REM_W'(pc_stat.count);
               if (i_ff == n_act - CNT_W'(1)) begin
                  i_in     = '0;
                  pos_in   = '0;
                  dv_in    = n_act;
                  state_in = ST_RK_RD;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_DG_RD;
               end
            end
         end
         // Rank: sweep degree values from high to low, indexes low to high.
         ST_RK_RD: begin
            state_in = ST_RK_CMP;
         end
         ST_RK_CMP: begin
            state_in = ST_RK_RD;
            if (i_ff == n_act - CNT_W'(1)) begin
               i_in  = '0;
               dv_in = dv_ff - CNT_W'(1);
            end else begin
               i_in  = i_ff + CNT_W'(1);
            end
            if (deg_rdata == dv_ff) begin
               ord_we = 1'b1;
               pos_in = pos_ff + CNT_W'(1);
               if (pos_ff + CNT_W'(1) == n_act) begin
                  i_in      = '0;
                  cmask_in  = '0;
                  pick_in   = '0;
                  greedy_in = '0;
                  state_in  = ST_GR_RD;
               end
            end
         end
         // Greedy bound: take each node that covers something new.
         ST_GR_RD: begin
            state_in = ST_GR_ADJ;
         end
         ST_GR_ADJ: begin
            adj_raddr = ord_rdata;
            idx_in    = ord_rdata;
            state_in  = ST_GR_UPD;
         end
         ST_GR_UPD: begin
            cmask_in = cmask_ff | adj_row;
            if ((adj_row & ~cmask_ff) != '0) begin
               pick_in   = pick_ff | idx_bit;
               greedy_in = greedy_ff + CNT_W'(1);
            end
            if (i_ff == n_act - CNT_W'(1)) begin
               state_in = ST_S_INIT;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_GR_RD;
            end
         end
         ST_S_INIT: begin
            best_set_in = pick_ff;
            best_cnt_in = greedy_ff;
            chosen_in   = '0;
            d_in        = '0;
            used_in     = '0;
            covered_in  = '0;
            popping_in  = 1'b0;
            for (int j = 0; j < MAX_NODES; j++) begin
               visit_in[j] = '0;
            end
            state_in = ST_S_FRM;
         end
         // New frame: prune on depth, bound and degree sum.
         ST_S_FRM: begin
            if (d_ff == n_act || used_ff >= best_cnt_ff ||
                rem_ff < REM_W'(n_act - covered_ff)) begin
               state_in = ST_S_LEAVE;
            end else begin
               phase_in   = PH_INCLUDE;
               popping_in = 1'b0;
               state_in   = ST_S_F0;
            end
         end
         ST_S_F0: begin
            ord_raddr = d_ff[N_W-1:0];
            frm_raddr = d_ff[N_W-1:0];
            state_in  = ST_S_F1;
         end
         ST_S_F1: begin
            adj_raddr = ord_rdata;
            deg_raddr = ord_rdata;
            idx_in    = ord_rdata;
            if (popping_ff) begin
               phase_in = frm_rdata[CNT_W+1:CNT_W];
               saved_in = frm_rdata[CNT_W-1:0];
            end
            state_in = ST_S_F2;
         end
         ST_S_F2: begin
            deg_in = deg_rdata;
            row_in = adj_row;
            if (popping_ff) begin
               rem_in     = rem_ff + REM_W'(deg_rdata);
               covered_in = saved_ff;
            end
            state_in = ST_S_EXEC;
         end
         ST_S_EXEC: begin
            case (phase_ff)
               PH_INCLUDE: begin
                  chosen_in = chosen_ff | idx_bit;
                  used_in   = used_ff + CNT_W'(1);
                  fresh_in  = (row_ff & ~cov_vec) != '0;
                  saved_in  = covered_ff;
                  for (int j = 0; j < MAX_NODES; j++) begin
                     visit_in[j] = visit_ff[j] + CNT_W'(row_ff[j]);
                  end
                  pc_vec   = cov_vec | row_ff;
                  pc_start = 1'b1;
                  state_in = ST_S_COV;
               end
               PH_EXCLUDE: begin
                  chosen_in  = chosen_ff & ~idx_bit;
                  used_in    = used_ff - CNT_W'(1);
                  for (int j = 0; j < MAX_NODES; j++) begin
                     visit_in[j] = visit_ff[j] - CNT_W'(row_ff[j]);
                  end
                  covered_in = saved_ff;
                  rem_in     = rem_ff - REM_W'(deg_ff);
                  frm_we     = 1'b1;
                  frm_wdata  = {PH_POP, saved_ff};
                  d_in       = d_ff + CNT_W'(1);
                  state_in   = ST_S_FRM;
               end
               default: begin
                  state_in = ST_S_LEAVE;
               end
            endcase
         end
         ST_S_COV: begin
            if (pc_stat.done) begin
               // Full cover with fewer nodes: keep it.
               if (pc_stat.count == n_act && used_ff < best_cnt_ff) begin
                  best_cnt_in = used_ff;
                  best_set_in = chosen_ff;
               end
               phase_in = PH_EXCLUDE;
               if (fresh_ff) begin
                  covered_in = pc_stat.count;
                  rem_in     = rem_ff - REM_W'(deg_ff);
                  frm_we     = 1'b1;
                  frm_wdata  = {PH_EXCLUDE, saved_ff};
                  d_in       = d_ff + CNT_W'(1);
                  state_in   = ST_S_FRM;
               end else begin
                  state_in   = ST_S_EXEC;
               end
            end
         end
         ST_S_LEAVE: begin
            if (d_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               d_in       = d_ff - CNT_W'(1);
               popping_in = 1'b1;
               state_in   = ST_S_F0;
            end
         end
         ST_DONE: begin
            // Hold until the result register is free, then drop the graph.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, 64'(best_set_ff), best_cnt_ff};
               row_vld_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         row_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         popping_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         row_vld_ff    <= row_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         popping_ff    <= popping_in;
      end
      row_vld_q_ff <= row_vld_ff[adj_raddr];
      a_ff         <= a_in;
      b_ff         <= b_in;
      i_ff         <= i_in;
      pos_ff       <= pos_in;
      dv_ff        <= dv_in;
      d_ff         <= d_in;
      used_ff      <= used_in;
      best_cnt_ff  <= best_cnt_in;
      covered_ff   <= covered_in;
      greedy_ff    <= greedy_in;
      saved_ff     <= saved_in;
      rem_ff       <= rem_in;
      idx_ff       <= idx_in;
      deg_ff       <= deg_in;
      row_ff       <= row_in;
      phase_ff     <= phase_in;
      fresh_ff     <= fresh_in;
      cmask_ff     <= cmask_in;
      pick_ff      <= pick_in;
      chosen_ff    <= chosen_in;
      best_set_ff  <= best_set_in;
      visit_ff     <= visit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      in_search |-> d_ff <= n_act)
      else $error("search depth beyond node count");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      in_search |-> {1'b0, used_ff} <= {1'b0, d_ff} + (CNT_W + 1)'(1))
      else $error("chosen count ahead of search depth");

   a_pc_no_restart: assert property (@(posedge clock) disable iff (reset)
      pc_start |-> !pc_stat.busy)
      else $error("popcount started while busy");

   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff && row_vld_ff == '0)
      else $error("result not loaded or graph not cleared");
`endif

endmodule
